// File: hdl/wmf_pkg.sv
// Shared types, constants and command/status structs of the weighted moment fusion block.
package wmf_pkg;

	// Port and accumulator widths
	localparam int FIELD_W    = 60;
	localparam int COUNT_W    = 24;
	localparam int WEIGHT_W   = 16;
	localparam int ACC_CNT_W  = 32;
	localparam int ACC_WT_W   = 32;
	localparam int TOT_W      = ACC_WT_W + 1;
	localparam int RATIO_BITS = 16;
	localparam int NUM_MEANS  = 6;

	// Parameter defaults
	localparam int DEF_COMP_WIDTH = 20;
	localparam int DEF_FRAC_BITS  = 10;

	// Register indexes of the configuration port
	localparam logic REG_WEIGHT_MODE = 1'b0;
	localparam logic REG_ADD_SPREAD  = 1'b1;

	// Sequencer step limits
	localparam logic [5:0] DIV_LAST  = 6'(RATIO_BITS);
	localparam logic [5:0] MEAN_OPS  = 6'd12;
	localparam logic [5:0] UV_SPLIT  = 6'd3;
	localparam logic [5:0] UV_LAST   = 6'd5;
	localparam logic [1:0] IDX_LAST  = 2'd2;
	localparam logic [1:0] PH_LAST   = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHK,
		S_DIV,
		S_MEAN,
		S_DEV,
		S_UV,
		S_COV,
		S_FLUSH,
		S_UPD,
		S_EMIT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_MEAN_A,
		OP_MEAN_B,
		OP_U,
		OP_V,
		OP_COV_A,
		OP_COV_B,
		OP_COV_U,
		OP_COV_V
	} op_t;

	typedef enum logic [1:0] {
		WB_NONE,
		WB_MEAN,
		WB_COV
	} wb_t;

	typedef struct packed {
		logic       load;
		logic       div_init;
		logic       div_step;
		logic       dev;
		logic       upd;
		logic       emit;
		op_t        op;
		logic [2:0] j;
		logic [1:0] r;
		logic [1:0] c;
		wb_t        wb;
		logic [2:0] wb_j;
		logic [1:0] wb_r;
		logic [1:0] wb_c;
	} cmd_t;

	typedef struct packed {
		logic tot_zero;
		logic last;
		logic out_busy;
	} stat_t;

	localparam cmd_t CMD_NONE = '{
		load: 1'b0, div_init: 1'b0, div_step: 1'b0, dev: 1'b0, upd: 1'b0,
		emit: 1'b0, op: OP_NONE, j: 3'd0, r: 2'd0, c: 2'd0,
		wb: WB_NONE, wb_j: 3'd0, wb_r: 2'd0, wb_c: 2'd0
	};

endpackage

// File: hdl/wmf_ctrl.sv
// Sequencer of the fusion block: handshake, divide, multiply schedule and emission.
module wmf_ctrl import wmf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_stall,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t     state_q, state_d;
	logic [5:0] step_q;
	logic [1:0] row_q, col_q, prow_q, pcol_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Step and covariance entry counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			row_q  <= '0;
			col_q  <= '0;
			prow_q <= '0;
			pcol_q <= '0;
		end else begin
			if (state_d != state_q) begin
				step_q <= '0;
			end else begin
				step_q <= step_q + 6'd1;
			end
			if (state_q == S_UV) begin
				row_q <= '0;
				col_q <= '0;
			end else if (state_q == S_COV && step_q[1:0] == PH_LAST) begin
				prow_q <= row_q;
				pcol_q <= col_q;
				if (col_q == IDX_LAST) begin
					col_q <= '0;
					row_q <= row_q + 2'd1;
				end else begin
					col_q <= col_q + 2'd1;
				end
			end
		end
	end

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		cmd        = CMD_NONE;
		item_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHK;
				end
			end
			S_CHK: begin
				if (stat.tot_zero) begin
					state_d = stat.last ? S_EMIT : S_IDLE;
				end else begin
					cmd.div_init = 1'b1;
					state_d      = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == DIV_LAST) begin
					state_d = S_MEAN;
				end
			end
			S_MEAN: begin
				// two products per mean component, each sum written back once its second product is in
				if (step_q < MEAN_OPS) begin
					cmd.op = step_q[0] ? OP_MEAN_B : OP_MEAN_A;
					cmd.j  = step_q[3:1];
				end
				if (!step_q[0] && step_q != 6'd0) begin
					cmd.wb   = WB_MEAN;
					cmd.wb_j = step_q[3:1] - 3'd1;
				end
				if (step_q == MEAN_OPS) begin
					state_d = S_DEV;
				end
			end
			S_DEV: begin
				cmd.dev = 1'b1;
				state_d = S_UV;
			end
			S_UV: begin
				if (step_q < UV_SPLIT) begin
					cmd.op = OP_U;
					cmd.r  = step_q[1:0];
				end else begin
					cmd.op = OP_V;
					cmd.r  = 2'(step_q - UV_SPLIT);
				end
				if (step_q == UV_LAST) begin
					state_d = S_COV;
				end
			end
			S_COV: begin
				// four products per entry: old, input, two spread terms
				cmd.r = row_q;
				cmd.c = col_q;
				unique case (step_q[1:0])
					2'd0: cmd.op = OP_COV_A;
					2'd1: cmd.op = OP_COV_B;
					2'd2: cmd.op = OP_COV_U;
					default: cmd.op = OP_COV_V;
				endcase
				if (step_q[1:0] == 2'd0 && (row_q != 2'd0 || col_q != 2'd0)) begin
					cmd.wb   = WB_COV;
					cmd.wb_r = prow_q;
					cmd.wb_c = pcol_q;
				end
				if (step_q[1:0] == PH_LAST && row_q == IDX_LAST && col_q == IDX_LAST) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				cmd.wb   = WB_COV;
				cmd.wb_r = prow_q;
				cmd.wb_c = pcol_q;
				state_d  = S_UPD;
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				state_d = stat.last ? S_EMIT : S_IDLE;
			end
			S_EMIT: begin
				if (!stat.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: hdl/wmf_datapath.sv
// Datapath of the fusion block: accumulators, ratio divider, shared multiplier and output word.
module wmf_datapath import wmf_pkg::*; #(
	parameter int COMP_WIDTH = DEF_COMP_WIDTH,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic                 cfg_data,
	input  logic [FIELD_W-1:0]   dataset_mean,
	input  logic [FIELD_W-1:0]   model_mean,
	input  logic [FIELD_W-1:0]   cov_row0,
	input  logic [FIELD_W-1:0]   cov_row1,
	input  logic [FIELD_W-1:0]   cov_row2,
	input  logic [COUNT_W-1:0]   count,
	input  logic [WEIGHT_W-1:0]  weight,
	input  logic                 last,
	input  cmd_t                 cmd,
	output stat_t                stat,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [FIELD_W-1:0]   out_dataset_mean,
	output logic [FIELD_W-1:0]   out_model_mean,
	output logic [FIELD_W-1:0]   out_cov_row0,
	output logic [FIELD_W-1:0]   out_cov_row1,
	output logic [FIELD_W-1:0]   out_cov_row2,
	output logic [ACC_CNT_W-1:0] out_count,
	output logic                 empty_res
);

	localparam int CW      = COMP_WIDTH;
	localparam int DW      = CW + 1;
	localparam int QW      = RATIO_BITS + 1;
	localparam int RW      = RATIO_BITS + 2;
	localparam int AW      = DW + RW;
	localparam int BW      = (DW > RW) ? DW : RW;
	localparam int PW      = AW + BW;
	localparam int MW      = PW + 2;
	localparam int EXT_W   = (3 * CW > FIELD_W) ? 3 * CW : FIELD_W;
	localparam int NUM_W   = TOT_W + RATIO_BITS + 1;
	localparam int MEAN_SH = RATIO_BITS;
	localparam int COV_SH  = FRAC_BITS + RATIO_BITS;
	localparam logic signed [MW-1:0] HALF_MEAN = MW'(1) << (MEAN_SH - 1);
	localparam logic signed [MW-1:0] HALF_COV  = MW'(1) << (COV_SH - 1);
	localparam logic signed [MW-1:0] SAT_HI    = (MW'(1) << (CW - 1)) - MW'(1);
	localparam logic signed [MW-1:0] SAT_LO    = -SAT_HI - MW'(1);

	// Configuration
	logic weight_mode_q, add_spread_q;

	// Captured input word
	logic signed [CW-1:0] in_mean_q [NUM_MEANS];
	logic signed [CW-1:0] in_cov_q  [3][3];
	logic [COUNT_W-1:0]   cnt_q;
	logic [COUNT_W-1:0]   w_q;
	logic [TOT_W-1:0]     tot_q;
	logic                 last_q;

	// Divider
	logic [TOT_W-1:0] rem_q;
	logic [QW-1:0]    num_lo_q;
	logic [QW-1:0]    quo_q;

	// Accumulators and working registers
	logic signed [CW-1:0] acc_mean_q [NUM_MEANS];
	logic signed [CW-1:0] acc_cov_q  [3][3];
	logic [ACC_CNT_W-1:0] acc_cnt_q;
	logic [ACC_WT_W-1:0]  acc_wt_q;
	logic signed [CW-1:0] new_mean_q [NUM_MEANS];
	logic signed [DW-1:0] ddo_q [3];
	logic signed [DW-1:0] dmo_q [3];
	logic signed [DW-1:0] ddi_q [3];
	logic signed [DW-1:0] dmi_q [3];
	logic signed [AW-1:0] u_q [3];
	logic signed [AW-1:0] v_q [3];
	logic signed [MW-1:0] mac_q;

	// Output word
	logic                 res_valid_q;
	logic [FIELD_W-1:0]   o_dm_q, o_mm_q, o_c0_q, o_c1_q, o_c2_q;
	logic [ACC_CNT_W-1:0] o_cnt_q;
	logic                 o_empty_q;

	// Combinational helpers
	logic [EXT_W-1:0]     ext_dm, ext_mm, ext_c0, ext_c1, ext_c2;
	logic [COUNT_W-1:0]   w_new;
	logic [NUM_W-1:0]     num;
	logic [TOT_W:0]       shifted;
	logic                 ge;
	logic signed [RW-1:0] r1_s, r2_s;
	logic signed [AW-1:0] a_sel;
	logic signed [BW-1:0] b_sel;
	logic signed [PW-1:0] prod;
	logic signed [MW-1:0] term;
	logic                 clr;
	logic signed [MW-1:0] rnd_mean, rnd_cov;
	logic signed [CW-1:0] mean_sat, cov_sat;
	logic [ACC_CNT_W:0]   cnt_sum;
	logic [EXT_W-1:0]     pk_dm, pk_mm, pk_c0, pk_c1, pk_c2;

	assign ext_dm = EXT_W'(dataset_mean);
	assign ext_mm = EXT_W'(model_mean);
	assign ext_c0 = EXT_W'(cov_row0);
	assign ext_c1 = EXT_W'(cov_row1);
	assign ext_c2 = EXT_W'(cov_row2);
	assign w_new  = weight_mode_q ? count : COUNT_W'(weight);

	// Ratio divider: one quotient bit per step
	assign num     = (NUM_W'(w_q) << RATIO_BITS) + NUM_W'(tot_q >> 1);
	assign shifted = {rem_q, num_lo_q[QW-1]};
	assign ge      = shifted >= {1'b0, tot_q};
	assign r2_s    = RW'(quo_q);
	assign r1_s    = (RW'(1) << RATIO_BITS) - r2_s;

	// Shared multiplier operand selection
	always_comb begin
		a_sel = '0;
		b_sel = '0;
		clr   = 1'b0;
		unique case (cmd.op)
			OP_MEAN_A: begin
				a_sel = AW'(acc_mean_q[cmd.j]);
				b_sel = BW'(r1_s);
				clr   = 1'b1;
			end
			OP_MEAN_B: begin
				a_sel = AW'(in_mean_q[cmd.j]);
				b_sel = BW'(r2_s);
			end
			OP_U: begin
				a_sel = AW'(dmo_q[cmd.r]);
				b_sel = BW'(r1_s);
			end
			OP_V: begin
				a_sel = AW'(dmi_q[cmd.r]);
				b_sel = BW'(r2_s);
			end
			OP_COV_A: begin
				a_sel = AW'(acc_cov_q[cmd.r][cmd.c]);
				b_sel = BW'(r1_s);
				clr   = 1'b1;
			end
			OP_COV_B: begin
				a_sel = AW'(in_cov_q[cmd.r][cmd.c]);
				b_sel = BW'(r2_s);
			end
			OP_COV_U: begin
				a_sel = u_q[cmd.r];
				b_sel = BW'(ddo_q[cmd.c]);
			end
			OP_COV_V: begin
				a_sel = v_q[cmd.r];
				b_sel = BW'(ddi_q[cmd.c]);
			end
			default: begin
				a_sel = '0;
			end
		endcase
	end

	assign prod = PW'(a_sel) * PW'(b_sel);

	// Accumulator input: old and input covariance terms carry the fraction shift
	always_comb begin
		term = MW'(prod);
		if (cmd.op == OP_COV_A || cmd.op == OP_COV_B) begin
			term = MW'(prod) <<< FRAC_BITS;
		end else if ((cmd.op == OP_COV_U || cmd.op == OP_COV_V) && !add_spread_q) begin
			term = '0;
		end
	end

	// Round half up and saturate the finished sum
	always_comb begin
		rnd_mean = (mac_q + HALF_MEAN) >>> MEAN_SH;
		rnd_cov  = (mac_q + HALF_COV) >>> COV_SH;
		if (rnd_mean > SAT_HI) begin
			mean_sat = SAT_HI[CW-1:0];
		end else if (rnd_mean < SAT_LO) begin
			mean_sat = SAT_LO[CW-1:0];
		end else begin
			mean_sat = rnd_mean[CW-1:0];
		end
		if (rnd_cov > SAT_HI) begin
			cov_sat = SAT_HI[CW-1:0];
		end else if (rnd_cov < SAT_LO) begin
			cov_sat = SAT_LO[CW-1:0];
		end else begin
			cov_sat = rnd_cov[CW-1:0];
		end
	end

	assign cnt_sum = (ACC_CNT_W + 1)'(acc_cnt_q) + (ACC_CNT_W + 1)'(cnt_q);

	// Pack the accumulators into result fields
	always_comb begin
		pk_dm = '0;
		pk_mm = '0;
		pk_c0 = '0;
		pk_c1 = '0;
		pk_c2 = '0;
		for (int k = 0; k < 3; k++) begin
			pk_dm[k*CW +: CW] = acc_mean_q[k];
			pk_mm[k*CW +: CW] = acc_mean_q[3+k];
			pk_c0[k*CW +: CW] = acc_cov_q[0][k];
			pk_c1[k*CW +: CW] = acc_cov_q[1][k];
			pk_c2[k*CW +: CW] = acc_cov_q[2][k];
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_mode_q <= 1'b0;
			add_spread_q  <= 1'b1;
		end else if (cfg_we) begin
			if (cfg_index == REG_WEIGHT_MODE) begin
				weight_mode_q <= cfg_data;
			end else if (cfg_index == REG_ADD_SPREAD) begin
				add_spread_q <= cfg_data;
			end
		end
	end

	// Input capture, divider and working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int k = 0; k < 3; k++) begin
				in_mean_q[k]   <= ext_dm[k*CW +: CW];
				in_mean_q[3+k] <= ext_mm[k*CW +: CW];
				in_cov_q[0][k] <= ext_c0[k*CW +: CW];
				in_cov_q[1][k] <= ext_c1[k*CW +: CW];
				in_cov_q[2][k] <= ext_c2[k*CW +: CW];
			end
			cnt_q  <= count;
			w_q    <= w_new;
			tot_q  <= TOT_W'(acc_wt_q) + TOT_W'(w_new);
			last_q <= last;
		end
		if (cmd.div_init) begin
			rem_q    <= TOT_W'(num >> QW);
			num_lo_q <= num[QW-1:0];
			quo_q    <= '0;
		end else if (cmd.div_step) begin
			rem_q    <= ge ? TOT_W'(shifted - {1'b0, tot_q}) : TOT_W'(shifted);
			num_lo_q <= num_lo_q << 1;
			quo_q    <= {quo_q[QW-2:0], ge};
		end
		if (cmd.op != OP_NONE) begin
			mac_q <= clr ? term : mac_q + term;
		end
		if (cmd.op == OP_U) begin
			u_q[cmd.r] <= AW'(prod);
		end
		if (cmd.op == OP_V) begin
			v_q[cmd.r] <= AW'(prod);
		end
		if (cmd.wb == WB_MEAN) begin
			new_mean_q[cmd.wb_j] <= mean_sat;
		end
		if (cmd.dev) begin
			for (int k = 0; k < 3; k++) begin
				ddo_q[k] <= DW'(acc_mean_q[k]) - DW'(new_mean_q[k]);
				dmo_q[k] <= DW'(acc_mean_q[3+k]) - DW'(new_mean_q[3+k]);
				ddi_q[k] <= DW'(in_mean_q[k]) - DW'(new_mean_q[k]);
				dmi_q[k] <= DW'(in_mean_q[3+k]) - DW'(new_mean_q[3+k]);
			end
		end
	end

	// Accumulators: covariance is rewritten in place, the rest on update; all clear on emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_MEANS; k++) begin
				acc_mean_q[k] <= '0;
			end
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					acc_cov_q[r][c] <= '0;
				end
			end
			acc_cnt_q <= '0;
			acc_wt_q  <= '0;
		end else if (cmd.emit) begin
			for (int k = 0; k < NUM_MEANS; k++) begin
				acc_mean_q[k] <= '0;
			end
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					acc_cov_q[r][c] <= '0;
				end
			end
			acc_cnt_q <= '0;
			acc_wt_q  <= '0;
		end else begin
			if (cmd.wb == WB_COV) begin
				acc_cov_q[cmd.wb_r][cmd.wb_c] <= cov_sat;
			end
			if (cmd.upd) begin
				for (int k = 0; k < NUM_MEANS; k++) begin
					acc_mean_q[k] <= new_mean_q[k];
				end
				acc_cnt_q <= cnt_sum[ACC_CNT_W] ? '1 : cnt_sum[ACC_CNT_W-1:0];
				acc_wt_q  <= tot_q[TOT_W-1] ? '1 : tot_q[ACC_WT_W-1:0];
			end
		end
	end

	// Output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Output word payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (acc_wt_q == '0) begin
				o_dm_q    <= '0;
				o_mm_q    <= '0;
				o_c0_q    <= '0;
				o_c1_q    <= '0;
				o_c2_q    <= '0;
				o_cnt_q   <= '0;
				o_empty_q <= 1'b1;
			end else begin
				o_dm_q    <= pk_dm[FIELD_W-1:0];
				o_mm_q    <= pk_mm[FIELD_W-1:0];
				o_c0_q    <= pk_c0[FIELD_W-1:0];
				o_c1_q    <= pk_c1[FIELD_W-1:0];
				o_c2_q    <= pk_c2[FIELD_W-1:0];
				o_cnt_q   <= acc_cnt_q;
				o_empty_q <= 1'b0;
			end
		end
	end

	assign stat.tot_zero = (tot_q == '0);
	assign stat.last     = last_q;
	assign stat.out_busy = res_valid_q && res_stall;

	assign res_valid        = res_valid_q;
	assign out_dataset_mean = o_dm_q;
	assign out_model_mean   = o_mm_q;
	assign out_cov_row0     = o_c0_q;
	assign out_cov_row1     = o_c1_q;
	assign out_cov_row2     = o_c2_q;
	assign out_count        = o_cnt_q;
	assign empty_res        = o_empty_q;

endmodule

// File: hdl/weighted_moment_fusion_top.sv
// Top level of the weighted moment fusion block: sequencer plus datapath.
// Merges per-source registration statistics (two means, a 3x3 cross-covariance, a count and
// a weight) into running weighted statistics and emits the fused word on the item marked
// last, then clears. One item is worked on at a time: an item with nonzero total weight
// passes through a check, the ratio divider at one quotient bit per cycle, 54 products on
// the single shared multiplier, the last mean write-back, the deviations, the last
// covariance write-back and the update, and then returns to idle to take the next word,
// with an emit step when it is marked last; an item whose total weight is zero goes from
// the check straight back to idle, or to emit. A finished result waits in its own output
// register, so the next word is taken while it is still stalled. The user must write
// configuration only while idle; the block itself does not enforce it.
module weighted_moment_fusion_top import wmf_pkg::*; #(
	parameter int COMP_WIDTH = DEF_COMP_WIDTH,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic                 cfg_data,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic [FIELD_W-1:0]   dataset_mean,
	input  logic [FIELD_W-1:0]   model_mean,
	input  logic [FIELD_W-1:0]   cov_row0,
	input  logic [FIELD_W-1:0]   cov_row1,
	input  logic [FIELD_W-1:0]   cov_row2,
	input  logic [COUNT_W-1:0]   count,
	input  logic [WEIGHT_W-1:0]  weight,
	input  logic                 last,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [FIELD_W-1:0]   out_dataset_mean,
	output logic [FIELD_W-1:0]   out_model_mean,
	output logic [FIELD_W-1:0]   out_cov_row0,
	output logic [FIELD_W-1:0]   out_cov_row1,
	output logic [FIELD_W-1:0]   out_cov_row2,
	output logic [ACC_CNT_W-1:0] out_count,
	output logic                 empty_res
);

	cmd_t  cmd;
	stat_t stat;

	wmf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	wmf_datapath #(
		.COMP_WIDTH (COMP_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.dataset_mean     (dataset_mean),
		.model_mean       (model_mean),
		.cov_row0         (cov_row0),
		.cov_row1         (cov_row1),
		.cov_row2         (cov_row2),
		.count            (count),
		.weight           (weight),
		.last             (last),
		.cmd              (cmd),
		.stat             (stat),
		.res_valid        (res_valid),
		.res_stall        (res_stall),
		.out_dataset_mean (out_dataset_mean),
		.out_model_mean   (out_model_mean),
		.out_cov_row0     (out_cov_row0),
		.out_cov_row1     (out_cov_row1),
		.out_cov_row2     (out_cov_row2),
		.out_count        (out_count),
		.empty_res        (empty_res)
	);

endmodule

// File: tb/tb_weighted_moment_fusion_top.sv
// Self-checking testbench for the weighted moment fusion block.
module tb_weighted_moment_fusion_top;
	import wmf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = DEF_COMP_WIDTH;
	localparam int FB = DEF_FRAC_BITS;
	localparam int RB = 16;
	localparam int WD_LIMIT = 4000;

	typedef struct {
		logic [FIELD_W-1:0]   dmean;
		logic [FIELD_W-1:0]   mmean;
		logic [FIELD_W-1:0]   cov [3];
		logic [ACC_CNT_W-1:0] cnt;
		logic                 empty;
	} fused_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0, cfg_index = 0, cfg_data = 0;
	logic item_valid = 0;
	logic item_stall;
	logic [FIELD_W-1:0] dataset_mean = '0, model_mean = '0;
	logic [FIELD_W-1:0] cov_row0 = '0, cov_row1 = '0, cov_row2 = '0;
	logic [COUNT_W-1:0] count = '0;
	logic [WEIGHT_W-1:0] weight = '0;
	logic last = 0;
	logic res_valid;
	logic res_stall = 0;
	logic [FIELD_W-1:0] out_dataset_mean, out_model_mean;
	logic [FIELD_W-1:0] out_cov_row0, out_cov_row1, out_cov_row2;
	logic [ACC_CNT_W-1:0] out_count;
	logic empty_res;

	weighted_moment_fusion_top dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Predictor state
	longint acc_d [3], acc_m [3], acc_c [3][3];
	longint unsigned acc_cnt, acc_wt;
	bit mode_count, spread_on;
	fused_t pending_fused [$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit stall_random = 1;

	function automatic longint comp_of(logic [FIELD_W-1:0] f, int k);
		logic [CW-1:0] u;
		u = f[k*CW +: CW];
		return longint'(signed'(u));
	endfunction

	function automatic logic [FIELD_W-1:0] pack_comps(longint v [3]);
		logic [FIELD_W-1:0] p;
		for (int k = 0; k < 3; k++) p[k*CW +: CW] = v[k][CW-1:0];
		return p;
	endfunction

	// floor((v + half) >> s) then clamp to component range
	function automatic longint round_clamp(longint v, int s);
		longint q, hi;
		q = (v + (longint'(1) << (s-1))) >>> s;
		hi = (longint'(1) << (CW-1)) - 1;
		if (q > hi) return hi;
		if (q < -hi-1) return -hi-1;
		return q;
	endfunction

	function automatic void clear_fusion();
		for (int r = 0; r < 3; r++) begin
			acc_d[r] = 0; acc_m[r] = 0;
			for (int c = 0; c < 3; c++) acc_c[r][c] = 0;
		end
		acc_cnt = 0; acc_wt = 0;
	endfunction

	function automatic void fuse_source(logic [FIELD_W-1:0] dm, logic [FIELD_W-1:0] mm,
			logic [FIELD_W-1:0] c0, logic [FIELD_W-1:0] c1, logic [FIELD_W-1:0] c2,
			logic [COUNT_W-1:0] cn, logic [WEIGHT_W-1:0] wt, logic lst);
		longint unsigned w, tot, s;
		longint r1, r2, acc;
		longint di [3], mi [3], nd [3], nm [3], ddo [3], dmo [3], ddi [3], dmi [3];
		longint nc [3][3];
		logic [FIELD_W-1:0] rows [3];
		fused_t f;
		rows[0] = c0; rows[1] = c1; rows[2] = c2;
		w = mode_count ? longint'(cn) : longint'(wt);
		tot = acc_wt + w;
		if (tot != 0) begin
			r2 = longint'(((w << RB) + tot / 2) / tot);
			r1 = (longint'(1) << RB) - r2;
			for (int r = 0; r < 3; r++) begin
				di[r] = comp_of(dm, r);
				mi[r] = comp_of(mm, r);
				nd[r] = round_clamp(acc_d[r] * r1 + di[r] * r2, RB);
				nm[r] = round_clamp(acc_m[r] * r1 + mi[r] * r2, RB);
				ddo[r] = acc_d[r] - nd[r]; dmo[r] = acc_m[r] - nm[r];
				ddi[r] = di[r] - nd[r]; dmi[r] = mi[r] - nm[r];
			end
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++) begin
					acc = (acc_c[r][c] * r1 + comp_of(rows[r], c) * r2) * (longint'(1) << FB);
					if (spread_on) acc += dmo[r] * ddo[c] * r1 + dmi[r] * ddi[c] * r2;
					nc[r][c] = round_clamp(acc, FB + RB);
				end
			acc_d = nd; acc_m = nm; acc_c = nc;
			s = acc_cnt + cn;
			acc_cnt = s > 64'hFFFFFFFF ? 64'hFFFFFFFF : s;
			acc_wt = tot > 64'hFFFFFFFF ? 64'hFFFFFFFF : tot;
		end
		if (!lst) return;
		if (acc_wt == 0) begin
			f.dmean = '0; f.mmean = '0; f.cov[0] = '0; f.cov[1] = '0; f.cov[2] = '0;
			f.cnt = '0; f.empty = 1;
		end else begin
			f.dmean = pack_comps(acc_d); f.mmean = pack_comps(acc_m);
			for (int r = 0; r < 3; r++) f.cov[r] = pack_comps(acc_c[r]);
			f.cnt = acc_cnt[31:0]; f.empty = 0;
		end
		pending_fused.insert(pending_fused.size(), f);
		clear_fusion();
	endfunction

	// Send one source word; predict at acceptance. Valid stays high into a
	// word sent with no gap; drain drops it after the last one.
	task automatic send_source(logic [FIELD_W-1:0] dm, logic [FIELD_W-1:0] mm,
			logic [FIELD_W-1:0] c0, logic [FIELD_W-1:0] c1, logic [FIELD_W-1:0] c2,
			logic [COUNT_W-1:0] cn, logic [WEIGHT_W-1:0] wt, logic lst, bit gaps = 1);
		int gap;
		gap = gaps ? $urandom_range(0, 15) : 0;
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			item_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		dataset_mean <= dm; model_mean <= mm; cov_row0 <= c0; cov_row1 <= c1;
		cov_row2 <= c2; count <= cn; weight <= wt; last <= lst; item_valid <= 1;
		do @(posedge clk); while (item_stall);
		fuse_source(dm, mm, c0, c1, c2, cn, wt, lst);
		@(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic val);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		if (idx == REG_WEIGHT_MODE) mode_count = val; else spread_on = val;
		@(negedge clk);
	endtask

	task automatic drain();
		item_valid <= 0;
		while (pending_fused.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	function automatic logic [FIELD_W-1:0] rnd_field();
		return FIELD_W'({$urandom(), $urandom()});
	endfunction

	// Small packed components (-2^b <= v < 2^b) to keep results away from the rails
	function automatic logic [FIELD_W-1:0] rnd_small(int b);
		longint v [3];
		for (int k = 0; k < 3; k++)
			v[k] = longint'($urandom_range(0, (1 << (b+1)) - 1)) - (longint'(1) << b);
		return pack_comps(v);
	endfunction

	function automatic logic [FIELD_W-1:0] rnd_any();
		case ($urandom_range(0, 3))
			0: return rnd_field();
			1: return rnd_small(8);
			default: return rnd_small(14);
		endcase
	endfunction

	task automatic send_random_pose(int n, bit gaps = 1);
		for (int i = 0; i < n; i++)
			send_source(rnd_any(), rnd_any(), rnd_any(), rnd_any(), rnd_any(),
				$urandom_range(0, 3) == 0 ? 24'($urandom()) : 24'($urandom_range(0, 300)),
				$urandom_range(0, 7) == 0 ? 16'd0 : 16'($urandom()),
				i == n - 1, gaps);
	endtask

	// Result checker
	always @(posedge clk) begin
		fused_t e;
		if (res_valid && !res_stall) begin
			if (pending_fused.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
			end else begin
				e = pending_fused.pop_front();
				if (out_dataset_mean !== e.dmean || out_model_mean !== e.mmean ||
						out_cov_row0 !== e.cov[0] || out_cov_row1 !== e.cov[1] ||
						out_cov_row2 !== e.cov[2] || out_count !== e.cnt ||
						empty_res !== e.empty) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch at %0t", $realtime);
						$display("  dmean exp %h got %h", e.dmean, out_dataset_mean);
						$display("  mmean exp %h got %h", e.mmean, out_model_mean);
						$display("  cov0 exp %h got %h", e.cov[0], out_cov_row0);
						$display("  cov1 exp %h got %h", e.cov[1], out_cov_row1);
						$display("  cov2 exp %h got %h", e.cov[2], out_cov_row2);
						$display("  count exp %h got %h empty exp %b got %b",
							e.cnt, out_count, e.empty, empty_res);
					end
				end
			end
		end
	end

	// Receiver stall: random stretches, or none while stall_random is clear
	initial begin
		int n;
		forever begin
			@(negedge clk);
			n = stall_random ? $urandom_range(0, 15) : 0;
			if (n != 0) begin
				res_stall <= 1;
				repeat (n) @(negedge clk);
				res_stall <= 0;
			end
			if (res_valid) @(negedge clk);
		end
	end

	// Watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (res_valid && !res_stall) || cfg_we ||
				pending_fused.size() == 0 && !item_valid)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("[weighted_moment_fusion_top] ERROR");
			$finish;
		end
	end

	task automatic test_extremes();
		logic [FIELD_W-1:0] mx, mn;
		mx = {3{1'b0, {(CW-1){1'b1}}}};
		mn = {3{1'b1, {(CW-1){1'b0}}}};
		send_source(mx, mn, mx, mn, mx, 24'hFFFFFF, 16'hFFFF, 0);
		send_source(mn, mx, mn, mx, mn, 24'd1, 16'hFFFF, 1);
		send_source('1, '0, '1, '0, '1, 24'd0, 16'd1, 1);
		send_source('0, '1, '0, '1, '0, 24'd5, 16'd0, 1);
		send_source(rnd_field(), rnd_field(), rnd_field(), rnd_field(), rnd_field(),
			24'd3, 16'd0, 0);
		send_source(rnd_field(), rnd_field(), rnd_field(), rnd_field(), rnd_field(),
			24'd7, 16'd256, 1);
		drain();
	endtask

	task automatic test_zero_weight();
		send_source(rnd_field(), rnd_field(), rnd_field(), rnd_field(), rnd_field(),
			24'd9, 16'd0, 1);
		send_source(rnd_small(8), rnd_small(8), rnd_small(8), rnd_small(8), rnd_small(8),
			24'd4, 16'd0, 0);
		send_source(rnd_small(8), rnd_small(8), rnd_small(8), rnd_small(8), rnd_small(8),
			24'd2, 16'd128, 1);
		drain();
	endtask

	task automatic test_count_saturation();
		write_reg(REG_WEIGHT_MODE, 1);
		for (int i = 0; i < 300; i++)
			send_source(rnd_small(10), rnd_small(10), rnd_small(10), rnd_small(10),
				rnd_small(10), 24'hFFFFFF, 16'($urandom()), i == 299, 0);
		drain();
	endtask

	task automatic test_mode_mix();
		write_reg(REG_WEIGHT_MODE, 1);
		send_random_pose(2);
		drain();
		write_reg(REG_WEIGHT_MODE, 0);
		send_random_pose(2);
		drain();
	endtask

	task automatic test_random(int n_items);
		int sent, len;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 40) == 0) begin
				drain();
				write_reg(REG_WEIGHT_MODE, $urandom_range(0, 1));
				write_reg(REG_ADD_SPREAD, $urandom_range(0, 1));
				stall_random = $urandom_range(0, 3) != 0;
			end
			len = $urandom_range(1, 8);
			send_random_pose(len);
			sent += len;
			if ($urandom_range(0, 30) == 0) drain();
		end
		stall_random = 1;
		drain();
	endtask

	initial begin
		mode_count = 0; spread_on = 1;
		clear_fusion();
		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_extremes();
		write_reg(REG_ADD_SPREAD, 0);
		test_extremes();
		write_reg(REG_ADD_SPREAD, 1);
		test_zero_weight();
		test_mode_mix();
		test_count_saturation();
		write_reg(REG_WEIGHT_MODE, 0);
		test_random(1600);
		if (mismatches == 0) $display("[weighted_moment_fusion_top] OK");
		else $display("[weighted_moment_fusion_top] ERROR");
		$finish;
	end
endmodule

// File: filelist.f
hdl/wmf_pkg.sv
hdl/wmf_ctrl.sv
hdl/wmf_datapath.sv
hdl/weighted_moment_fusion_top.sv
tb/tb_weighted_moment_fusion_top.sv
